// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/npcs_pkg.sv =====
package npcs_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
    localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);
    localparam int COUNT_W         = 9;
    localparam int WIDE_W          = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;
    localparam int CHAN_W          = 8;
    localparam int DIST_W          = 10;
    localparam int INDEX_W         = 8;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } rgb_t;

    localparam int RGB_W = $bits(rgb_t);

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== rtl/npcs_ram.sv =====
module npcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/nearest_palette_color_search.sv =====
// Write beat: accepted while idle, no result.
// Pixel beat: scans entries 0 to limit - 1 and registers the nearest index as the result,
// limit = min(palette_count, entries); one palette entry compared per cycle via one RAM port.
// Input: beats are taken only in idle; none during a search or while DONE waits to load the output.
// Reset clears control state and palette_count; palette contents stay undefined until written.
`include "assert_macros.svh"

module nearest_palette_color_search
    import npcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [COUNT_W-1:0]   cfg_write_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [INDEX_W-1:0]   entry_index,
    input  logic [CHAN_W-1:0]    red,
    input  logic [CHAN_W-1:0]    green,
    input  logic [CHAN_W-1:0]    blue,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [INDEX_W-1:0]   palette_index
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]    limit_reg;
    logic [CNT_W-1:0]    issue_cnt_reg;
    logic                cmp_valid_reg;
    logic [ADDR_W-1:0]   cmp_idx_reg;
    logic [DIST_W-1:0]   best_dist_reg;
    logic [ADDR_W-1:0]   best_idx_reg;
    rgb_t                pixel_reg;
    logic                out_valid_reg;
    logic [INDEX_W-1:0]  out_index_reg;

    logic                in_fire;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic                issue;
    logic [CNT_W-1:0]    limit_calc;
    rgb_t                wr_data;
    rgb_t                entry;
    logic [DIST_W-1:0]   entry_dist;
    logic                load_out;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign wr_en    = in_fire && (kind == KIND_WRITE)
                      && (WIDE_W'(entry_index) < WIDE_W'(PALETTE_ENTRIES));
    assign wr_addr  = ADDR_W'(entry_index);
    assign wr_data  = '{r: red, g: green, b: blue};

    assign limit_calc = (WIDE_W'(count_reg) > WIDE_W'(PALETTE_ENTRIES))
                        ? CNT_W'(PALETTE_ENTRIES) : CNT_W'(count_reg);

    assign issue = (state_reg == ST_SCAN) && (issue_cnt_reg < limit_reg);

    npcs_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (issue_cnt_reg[ADDR_W-1:0]),
        .rdata (entry)
    );

    assign entry_dist = DIST_W'(abs_diff(pixel_reg.r, entry.r))
                      + DIST_W'(abs_diff(pixel_reg.g, entry.g))
                      + DIST_W'(abs_diff(pixel_reg.b, entry.b));

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (kind == KIND_PIXEL))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issue && !cmp_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            issue_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= issue;
            if (cfg_write_en)
            begin
                count_reg <= cfg_write_data;
            end
            if (in_fire)
            begin
                issue_cnt_reg <= '0;
            end
            else if (issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= issue_cnt_reg[ADDR_W-1:0];
        if (in_fire)
        begin
            pixel_reg     <= wr_data;
            limit_reg     <= limit_calc;
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
        end
        else if (cmp_valid_reg && (entry_dist < best_dist_reg))
        begin
            best_dist_reg <= entry_dist;
            best_idx_reg  <= cmp_idx_reg;
        end
        if (load_out)
        begin
            out_index_reg <= INDEX_W'(best_idx_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign palette_index = out_index_reg;

    `ASSERT_NOW(a_scan_bound, state_reg == ST_SCAN, issue_cnt_reg <= limit_reg)
    `ASSERT_NOW(a_cmp_in_scan, cmp_valid_reg, state_reg == ST_SCAN)
    `ASSERT_NOW(a_best_in_range, (state_reg == ST_DONE) && (limit_reg != '0),
                CNT_W'(best_idx_reg) < limit_reg)
    `ASSERT_NEXT(a_pixel_starts, in_fire && (kind == KIND_PIXEL),
                 (state_reg == ST_SCAN) && (issue_cnt_reg == '0))

endmodule
